[src/fatcm_pkg.sv]
// ----------------------------------------------------------------------------
// fatcm_pkg: shared constants for the two's-complement mantissa float adder
// Error codes and default widths.
// ----------------------------------------------------------------------------
`default_nettype none
package fatcm_pkg;
  localparam int unsigned MantWidth = 10;
  localparam int unsigned ExpWidth  = 6;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_POS_OVF   = 2'd1,
    ERR_NEG_OVF   = 2'd2,
    ERR_UNDERFLOW = 2'd3
  } err_e;
endpackage
`default_nettype wire

[src/float_add_twos_complement_mantissa.sv]
// ----------------------------------------------------------------------------
// float_add_twos_complement_mantissa: iterative float adder
// Aligns by one-bit shift steps, adds, then normalizes one bit per cycle.
// ----------------------------------------------------------------------------
// channel  | direction | handshake           | word
// command  | in        | start_i && !busy_o  | a/b mantissa, a/b exponent
// result   | out       | valid_o (one cycle) | error_code, sum mantissa/exponent
//
// A pair whose exponents are MANT_WIDTH or more apart returns in the next
// cycle; otherwise a one-bit shifter does the alignment in S_ALIGN, S_ADD
// adds, then S_NORM does the left normalization. The receiver cannot stall;
// busy_o drops in the cycle the result is shown. Reset clears the sequencer
// and valid_o.
`default_nettype none
module float_add_twos_complement_mantissa #(
  parameter int unsigned MANT_WIDTH = fatcm_pkg::MantWidth,
  parameter int unsigned EXP_WIDTH  = fatcm_pkg::ExpWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [MANT_WIDTH-1:0] a_mantissa_i,
  input  wire logic        [EXP_WIDTH-1:0]  a_exponent_i,
  input  wire logic signed [MANT_WIDTH-1:0] b_mantissa_i,
  input  wire logic        [EXP_WIDTH-1:0]  b_exponent_i,
  output logic                              valid_o,
  output logic             [1:0]            error_code_o,
  output logic signed [MANT_WIDTH-1:0]      sum_mantissa_o,
  output logic        [EXP_WIDTH-1:0]       sum_exponent_o
);
  localparam int unsigned SW = MANT_WIDTH + 1;
  localparam int unsigned CW = EXP_WIDTH + 1;

  typedef enum logic [1:0] {S_IDLE, S_ALIGN, S_ADD, S_NORM} state_e;

  state_e               state_q;
  logic [SW-1:0]        big_q, sml_q;
  logic [EXP_WIDTH-1:0] cnt_q;
  logic signed [CW:0]   cr_q;
  logic                 first_q;

  logic                 swap;
  logic [EXP_WIDTH-1:0] ea, eb, diff;
  logic [SW-1:0]        sum, shl;
  logic                 differ;

  assign swap   = a_exponent_i < b_exponent_i;
  assign ea     = swap ? b_exponent_i : a_exponent_i;
  assign eb     = swap ? a_exponent_i : b_exponent_i;
  assign diff   = ea - eb;
  assign sum    = big_q + sml_q;
  assign shl    = {big_q[SW-2:0], 1'b0};
  assign differ = big_q[SW-1] ^ big_q[SW-2];
  assign busy_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            big_q <= swap ? {b_mantissa_i[MANT_WIDTH-1], b_mantissa_i}
                          : {a_mantissa_i[MANT_WIDTH-1], a_mantissa_i};
            sml_q <= swap ? {a_mantissa_i[MANT_WIDTH-1], a_mantissa_i}
                          : {b_mantissa_i[MANT_WIDTH-1], b_mantissa_i};
            cnt_q <= diff;
            cr_q  <= (CW+1)'(ea);
            if ({{(32-EXP_WIDTH){1'b0}}, diff} >= MANT_WIDTH) begin
              valid_o        <= 1'b1;
              error_code_o   <= fatcm_pkg::ERR_NONE;
              sum_mantissa_o <= swap ? b_mantissa_i : a_mantissa_i;
              sum_exponent_o <= ea;
            end else begin
              state_q <= S_ALIGN;
            end
          end
        end
        S_ALIGN: begin
          if (cnt_q == '0) begin
            state_q <= S_ADD;
          end else begin
            sml_q <= {sml_q[SW-1], sml_q[SW-1:1]};
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_ADD: begin
          first_q <= 1'b1;
          if (sum == '0) begin
            valid_o        <= 1'b1;
            error_code_o   <= fatcm_pkg::ERR_NONE;
            sum_mantissa_o <= '0;
            sum_exponent_o <= '0;
            state_q        <= S_IDLE;
          end else if (sum[SW-1] ^ sum[SW-2]) begin
            valid_o <= 1'b1;
            state_q <= S_IDLE;
            if (cr_q + 1 >= (CW+1)'(1 << EXP_WIDTH)) begin
              error_code_o   <= sum[SW-1] ? fatcm_pkg::ERR_NEG_OVF
                                          : fatcm_pkg::ERR_POS_OVF;
              sum_mantissa_o <= '0;
              sum_exponent_o <= '0;
            end else begin
              error_code_o   <= fatcm_pkg::ERR_NONE;
              sum_mantissa_o <= sum[SW-1:1];
              sum_exponent_o <= EXP_WIDTH'(cr_q + 1);
            end
          end else begin
            big_q   <= {sum[SW-2:0], 1'b0};
            state_q <= S_NORM;
          end
        end
        S_NORM: begin
          if (differ) begin
            valid_o        <= 1'b1;
            error_code_o   <= fatcm_pkg::ERR_NONE;
            sum_mantissa_o <= big_q[SW-1:1];
            sum_exponent_o <= EXP_WIDTH'(cr_q);
            state_q        <= S_IDLE;
          end else if (cr_q == '0) begin
            valid_o        <= 1'b1;
            error_code_o   <= fatcm_pkg::ERR_UNDERFLOW;
            sum_mantissa_o <= '0;
            sum_exponent_o <= '0;
            state_q        <= S_IDLE;
          end else begin
            big_q   <= shl;
            cr_q    <= (CW+1)'(cr_q - 1);
            first_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && error_code_o != fatcm_pkg::ERR_NONE |-> sum_mantissa_o == '0)
    else $error("error result with nonzero mantissa");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALIGN |=> state_q == S_ALIGN || state_q == S_ADD)
    else $error("align left badly");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NORM && !first_q |-> cr_q >= 0)
    else $error("exponent went negative");
endmodule
`default_nettype wire
